// ===== rtl/sapt_pkg.sv =====
// Types, codes and control store of the set-associative position table.
package sapt_pkg;

	// Field widths
	localparam int FUNC_W     = 2;
	localparam int HASH_W     = 32;
	localparam int POS_W      = 64;
	localparam int DEPTH_W    = 8;
	localparam int KIND_W     = 2;
	localparam int SCORE_W    = 16;
	localparam int LOGSETS_W  = 4;
	localparam int WAYSCFG_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Register reset values
	localparam logic [LOGSETS_W-1:0] LOG_SETS_RST = 4'd10;
	localparam logic [WAYSCFG_W-1:0] WAYS_RST     = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOG_SETS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd1;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// Victim remainder: digits of the shifted hash taken per step
	localparam int REM_DIGIT = 8;
	localparam int REM_STEPS = HASH_W / REM_DIGIT;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	// Microprogram addresses
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LK_RD,
		ST_LK_CMP,
		ST_LK_OUT,
		ST_IN_RD,
		ST_IN_REM,
		ST_IN_WR,
		ST_CLEAR
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_DISPATCH,
		COND_LOOKUP,
		COND_REMAIN,
		COND_CLEAR,
		COND_OUT
	} cond_t;

	// One control word
	typedef struct packed {
		logic  take;
		logic  rd_row;
		logic  rd_data;
		logic  rem_init;
		logic  rem;
		logic  cmp;
		logic  emit;
		logic  wr_ins;
		logic  wr_clr;
		cond_t cond;
		step_t jt;
		step_t jf;
	} ctrl_t;

	// Status seen by the sequencer
	typedef struct packed {
		logic              accept;
		logic [FUNC_W-1:0] func;
		logic              lk_more;
		logic              rem_more;
		logic              clr_more;
		logic              out_free;
	} stat_t;

	// Control store
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '0;
		c.cond = COND_ALWAYS;
		c.jt   = ST_IDLE;
		c.jf   = ST_IDLE;
		case (s)
			ST_IDLE: begin
				c.take = 1'b1;
				c.cond = COND_DISPATCH;
			end
			ST_LK_RD: begin
				c.rd_row  = 1'b1;
				c.rd_data = 1'b1;
				c.jt      = ST_LK_CMP;
			end
			ST_LK_CMP: begin
				c.rd_data = 1'b1;
				c.cmp     = 1'b1;
				c.cond    = COND_LOOKUP;
				c.jt      = ST_LK_CMP;
				c.jf      = ST_LK_OUT;
			end
			ST_LK_OUT: begin
				c.emit = 1'b1;
				c.cond = COND_OUT;
				c.jt   = ST_IDLE;
				c.jf   = ST_LK_OUT;
			end
			ST_IN_RD: begin
				c.rd_row   = 1'b1;
				c.rem_init = 1'b1;
				c.jt       = ST_IN_REM;
			end
			ST_IN_REM: begin
				c.rem  = 1'b1;
				c.cond = COND_REMAIN;
				c.jt   = ST_IN_REM;
				c.jf   = ST_IN_WR;
			end
			ST_IN_WR: begin
				c.wr_ins = 1'b1;
			end
			ST_CLEAR: begin
				c.wr_clr = 1'b1;
				c.cond   = COND_CLEAR;
				c.jt     = ST_CLEAR;
				c.jf     = ST_IDLE;
			end
			default: begin
				c.jt = ST_IDLE;
			end
		endcase
		return c;
	endfunction

	// Entry point for each operation
	function automatic step_t dispatch(input logic [FUNC_W-1:0] f);
		step_t s;
		case (f)
			FUNC_LOOKUP: s = ST_LK_RD;
			FUNC_INSERT: s = ST_IN_RD;
			FUNC_CLEAR:  s = ST_CLEAR;
			default:     s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/sapt_sequencer.sv =====
// Step counter and control store walker of the position table.
module sapt_sequencer import sapt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	step_t step_d;

	// Current control word
	assign ctrl = ucode(step_q);

	// Next step from the jump condition
	always_comb begin
		step_d = ctrl.jf;
		case (ctrl.cond)
			COND_ALWAYS:   step_d = ctrl.jt;
			COND_DISPATCH: step_d = stat.accept ? dispatch(stat.func) : ctrl.jf;
			COND_LOOKUP:   step_d = stat.lk_more ? ctrl.jt : ctrl.jf;
			COND_REMAIN:   step_d = stat.rem_more ? ctrl.jt : ctrl.jf;
			COND_CLEAR:    step_d = stat.clr_more ? ctrl.jt : ctrl.jf;
			COND_OUT:      step_d = stat.out_free ? ctrl.jt : ctrl.jf;
			default:       step_d = ST_IDLE;
		endcase
	end

	// Reset starts with a clearing pass of the valid store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== rtl/set_assoc_position_table_unit.sv =====
// Top level of the set-associative position table: datapath, stores and config.
//
// Usage: the in channel (in_valid/in_ready) takes one word per operation:
// func selects lookup, insert or clear. Each lookup yields one word on the
// out channel (out_valid/out_ready) with hit, found_kind and found_score;
// insert, clear and the unused code yield nothing. The cfg channel writes
// log_sets (index 0) and ways (index 1) and is always ready; write it only
// while the table is idle.
// Timing: one operation is in hand at a time. A lookup probes w ways, w being
// at most the number of ways in use, one way per cycle from the entry store's
// single read port. An insert works out the victim way, the shifted hash
// modulo ways, a byte per cycle. A clear sweeps all 2**MAX_LOG_SETS set rows
// of the valid store, one set row a cycle.
// Reset: registers go to log_sets 10 and ways 4, and the same clearing pass
// over all set rows runs before in_ready first rises.
// Stall: a finished lookup word sits in the output register; the next
// operation is still taken, and the unit waits only when a second lookup
// word is ready before the first has been taken.
module set_assoc_position_table_unit import sapt_pkg::*; #(
	parameter int MAX_LOG_SETS = 10,
	parameter int MAX_WAYS     = 4,
	parameter int KEY_BITS     = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [FUNC_W-1:0]            func,
	input  logic [HASH_W-1:0]            hash_code,
	input  logic [POS_W-1:0]             position_key,
	input  logic [DEPTH_W-1:0]           search_depth,
	input  logic [KIND_W-1:0]            node_kind,
	input  logic signed [SCORE_W-1:0]    score,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [KIND_W-1:0]            found_kind,
	output logic signed [SCORE_W-1:0]    found_score,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int NUM_SETS    = 2 ** MAX_LOG_SETS;
	localparam int NUM_ENTRIES = NUM_SETS * MAX_WAYS;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int SET_W       = MAX_LOG_SETS;
	localparam int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W        = $clog2(MAX_WAYS + 1);
	localparam int LS_W        = $clog2(MAX_LOG_SETS + 1);
	localparam int ENTRY_W     = KEY_BITS + DEPTH_W + KIND_W + SCORE_W;

	ctrl_t ctrl;
	stat_t stat;

	logic [LOGSETS_W-1:0] log_sets_q;
	logic [WAYSCFG_W-1:0] ways_q;
	logic [LS_W-1:0]      ls_eff;
	logic [NW_W-1:0]      nw_eff;

	logic                 in_accept;
	logic [HASH_W-1:0]    hash_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [KIND_W-1:0]    kind_q;
	logic [SCORE_W-1:0]   score_q;

	logic [SET_W-1:0]     set_idx;
	logic [ADDR_W-1:0]    base_addr;
	logic [WAY_W-1:0]     way_q;
	logic [WAY_W-1:0]     way_d;
	logic                 way_last;
	logic                 match;

	logic [ENTRY_W-1:0]   dmem [NUM_ENTRIES];
	logic [ENTRY_W-1:0]   drd_q;
	logic [MAX_WAYS-1:0]  vmem [NUM_SETS];
	logic [MAX_WAYS-1:0]  row_q;
	logic [SET_W-1:0]     clr_addr_q;

	logic [HASH_W-1:0]    dv_q;
	logic [NW_W-1:0]      rem_q;
	logic [NW_W-1:0]      rem_d;
	logic [NW_W:0]        rem_t;
	logic [NW_W-1:0]      rem_r;
	logic [REM_CNT_W-1:0] rcnt_q;
	logic [WAY_W-1:0]     slot;

	logic                 res_hit_q;
	logic [KIND_W-1:0]    res_kind_q;
	logic [SCORE_W-1:0]   res_score_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 out_load;
	logic                 hit_q;
	logic [KIND_W-1:0]    found_kind_q;
	logic [SCORE_W-1:0]   found_score_q;

	// Fields of the word read from the entry store
	logic [KEY_BITS-1:0]  rd_key;
	logic [DEPTH_W-1:0]   rd_depth;
	logic [KIND_W-1:0]    rd_kind;
	logic [SCORE_W-1:0]   rd_score;

	assign rd_key   = drd_q[ENTRY_W-1 -: KEY_BITS];
	assign rd_depth = drd_q[SCORE_W+KIND_W +: DEPTH_W];
	assign rd_kind  = drd_q[SCORE_W +: KIND_W];
	assign rd_score = drd_q[SCORE_W-1:0];

	// Sequencer
	sapt_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign in_ready  = ctrl.take;
	assign in_accept = in_valid & ctrl.take;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_sets_q <= LOG_SETS_RST;
			ways_q     <= WAYS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOG_SETS: log_sets_q <= cfg_data;
				REG_WAYS:     ways_q     <= cfg_data[WAYSCFG_W-1:0];
				default:      ;
			endcase
		end
	end

	// Saturated set count and way count
	assign ls_eff = (32'(log_sets_q) > 32'(MAX_LOG_SETS)) ? LS_W'(MAX_LOG_SETS)
	                                                       : LS_W'(log_sets_q);
	always_comb begin
		if (ways_q == '0) begin
			nw_eff = NW_W'(1);
		end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
			nw_eff = NW_W'(MAX_WAYS);
		end else begin
			nw_eff = NW_W'(ways_q);
		end
	end

	// Operand latch
	always_ff @(posedge clk) begin
		if (in_accept) begin
			hash_q  <= hash_code;
			key_q   <= position_key[KEY_BITS-1:0];
			depth_q <= search_depth;
			kind_q  <= node_kind;
			score_q <= score;
		end
	end

	// Set index and entry base address
	always_comb begin
		for (int i = 0; i < SET_W; i++) begin
			set_idx[i] = hash_q[i] & (i < int'(ls_eff));
		end
	end
	assign base_addr = ADDR_W'(set_idx) * ADDR_W'(MAX_WAYS);

	// Way probe
	assign way_last = (NW_W'(way_q) == nw_eff - NW_W'(1));
	assign match    = row_q[way_q] && (rd_depth == depth_q) && (rd_key == key_q);
	assign stat.lk_more = ctrl.cmp && !match && !way_last;

	always_comb begin
		if (in_accept) begin
			way_d = '0;
		end else if (stat.lk_more) begin
			way_d = way_q + WAY_W'(1);
		end else begin
			way_d = way_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q <= '0;
		end else begin
			way_q <= way_d;
		end
	end

	// Lookup result; cleared per operation
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_hit_q   <= 1'b0;
			res_kind_q  <= '0;
			res_score_q <= '0;
		end else if (ctrl.cmp && match) begin
			res_hit_q   <= 1'b1;
			res_kind_q  <= rd_kind;
			res_score_q <= rd_score;
		end
	end

	// Victim remainder, one byte of the shifted hash per step
	always_comb begin
		rem_r = rem_q;
		rem_t = '0;
		for (int k = 0; k < REM_DIGIT; k++) begin
			rem_t = {rem_r, dv_q[HASH_W-1-k]};
			if (rem_t >= {1'b0, nw_eff}) begin
				rem_t = rem_t - {1'b0, nw_eff};
			end
			rem_r = rem_t[NW_W-1:0];
		end
		rem_d = rem_r;
	end

	assign stat.rem_more = (rcnt_q != REM_CNT_W'(REM_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (ctrl.rem_init) begin
			rcnt_q <= '0;
		end else if (ctrl.rem) begin
			rcnt_q <= rcnt_q + REM_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rem_init) begin
			dv_q  <= hash_q >> ls_eff;
			rem_q <= '0;
		end else if (ctrl.rem) begin
			dv_q  <= dv_q << REM_DIGIT;
			rem_q <= rem_d;
		end
	end

	// Insert slot: first free way in use, else the victim way
	always_comb begin
		slot = WAY_W'(rem_q);
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if ((w < int'(nw_eff)) && !row_q[w]) begin
				slot = WAY_W'(w);
			end
		end
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.wr_ins) begin
			dmem[base_addr + ADDR_W'(slot)] <= {key_q, depth_q, kind_q, score_q};
		end
		if (ctrl.rd_data) begin
			drd_q <= dmem[base_addr + ADDR_W'(way_d)];
		end
	end

	// Valid store, one row of way bits per set
	always_ff @(posedge clk) begin
		if (ctrl.wr_clr) begin
			vmem[clr_addr_q] <= '0;
		end else if (ctrl.wr_ins) begin
			vmem[set_idx] <= row_q | (MAX_WAYS'(1) << slot);
		end
		if (ctrl.rd_row) begin
			row_q <= vmem[set_idx];
		end
	end

	// Clearing sweep address; wraps back to zero at the end of a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (ctrl.wr_clr) begin
			clr_addr_q <= clr_addr_q + SET_W'(1);
		end
	end
	assign stat.clr_more = (clr_addr_q != {SET_W{1'b1}});

	// Output register
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ctrl.emit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q         <= res_hit_q;
			found_kind_q  <= res_kind_q;
			found_score_q <= res_score_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign found_kind  = found_kind_q;
	assign found_score = found_score_q;

	// Sequencer status
	assign stat.accept   = in_accept;
	assign stat.func     = func;
	assign stat.out_free = out_free;

	// Probe never runs past the ways in use
	a_way_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmp |-> (NW_W'(way_q) < nw_eff))
		else $error("way probe beyond ways in use");

	// Victim way is below the way count when the insert is written
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_ins |-> (rem_q < nw_eff))
		else $error("victim remainder out of range");

	// A pending result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// A clear sweep always starts from the first set
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (func == FUNC_CLEAR)) |-> (clr_addr_q == '0))
		else $error("clear sweep not aligned");

endmodule
